@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at each rising clock edge, disabled in reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same check, also active during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/sksm_pkg.sv @@
// Package: shared types and codes for the sorted key set.
package sksm_pkg;
    localparam int CAPACITY = 64;
    localparam int KEY_W    = 27;
    localparam int GRADE_W  = 7;
    localparam int CNT_W    = 7;
    localparam int SUM_W    = 13;
    localparam int MEAN_W   = 8;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 24;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    localparam logic signed [MEAN_W-1:0] MEAN_NONE = -8'sd1;

    typedef struct packed {
        logic               func;
        logic [KEY_W-1:0]   key;
        logic               has_grade;
        logic [GRADE_W-1:0] grade_tenths;
    } sksm_cmd_t;

    typedef struct packed {
        logic                     key_was_present;
        logic                     table_full;
        logic [CNT_W-1:0]         set_size;
        logic [CNT_W-1:0]         graded_count;
        logic signed [MEAN_W-1:0] mean_grade_tenths;
    } sksm_res_t;
endpackage

@@ hdl/sksm_front.sv @@
// Front part: command queue between the input and the back part.
module sksm_front #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sksm_pkg::sksm_cmd_t in_cmd,
    output logic                q_valid,
    input  logic                q_ready,
    output sksm_pkg::sksm_cmd_t q_cmd
);
    import sksm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sksm_cmd_t        mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH)) ? 1'b1 : 1'b0;
    assign q_valid  = (cnt_reg != '0);
    assign q_cmd    = mem_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_cmd;
        end
    end
endmodule

@@ hdl/sksm_back.sv @@
// Back part: binary search, shift, running totals, serial mean divider.
module sksm_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_ready,
    input  sksm_pkg::sksm_cmd_t q_cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output sksm_pkg::sksm_res_t res
);
    import sksm_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int NW = AW + 1;
    localparam int EW = KEY_W + 1 + GRADE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SRCH   = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_SHIFT  = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;
    localparam logic [2:0] ST_RDWAIT = 3'd6;

    logic [EW-1:0]        mem [CAPACITY];
    logic [EW-1:0]        rdata_reg;
    logic [AW-1:0]        raddr;
    logic                 ren;
    logic [AW-1:0]        waddr;
    logic [EW-1:0]        wdata;
    logic                 wen;

    logic [2:0]           st_reg, st_next;
    sksm_cmd_t            cmd_reg;
    logic [NW-1:0]        lo_reg, lo_next, hi_reg, hi_next;
    logic [NW-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]     gcnt_reg, gcnt_next;
    logic [SUM_W-1:0]     gsum_reg, gsum_next;
    logic [NW-1:0]        idx_reg, idx_next;
    logic                 pres_reg, pres_next, full_reg, full_next;
    logic                 phase_reg, phase_next;
    logic [EW-1:0]        hold_reg, hold_next;
    logic [SUM_W-1:0]     rem_reg, rem_next, quo_reg, quo_next;
    logic [3:0]           dcnt_reg, dcnt_next;
    logic                 rv_reg;
    sksm_res_t            res_reg, res_next;
    logic                 load_res;
    logic [NW-1:0]        mid;
    logic [KEY_W-1:0]     rkey;
    logic                 rflag;
    logic [GRADE_W-1:0]   rgrade;
    logic [SUM_W-1:0]     trial;
    logic [SUM_W-1:0]     sub_g;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign rkey   = rdata_reg[EW-1 -: KEY_W];
    assign rflag  = rdata_reg[GRADE_W];
    assign rgrade = rdata_reg[GRADE_W-1:0];
    assign trial  = {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
    assign sub_g  = SUM_W'(rgrade);

    assign q_ready   = (st_reg == ST_IDLE);
    assign res_valid = rv_reg;
    assign res       = res_reg;

    always_comb
    begin
        st_next    = st_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        cnt_next   = cnt_reg;
        gcnt_next  = gcnt_reg;
        gsum_next  = gsum_reg;
        idx_next   = idx_reg;
        pres_next  = pres_reg;
        full_next  = full_reg;
        phase_next = phase_reg;
        hold_next  = hold_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dcnt_next  = dcnt_reg;
        res_next   = res_reg;
        load_res   = 1'b0;
        ren        = 1'b0;
        raddr      = mid[AW-1:0];
        wen        = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = hold_reg;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    lo_next   = '0;
                    hi_next   = cnt_reg;
                    pres_next = 1'b0;
                    full_next = 1'b0;
                    st_next   = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    ren     = 1'b1;
                    st_next = ST_RDWAIT;
                end
                else
                begin
                    ren     = (lo_reg < cnt_reg);
                    raddr   = lo_reg[AW-1:0];
                    st_next = ST_CHECK;
                end
            end
            ST_RDWAIT:
            begin
                if (rkey < cmd_reg.key)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                st_next = ST_SRCH;
            end
            ST_CHECK:
            begin
                pres_next = (lo_reg < cnt_reg) && (rkey == cmd_reg.key);
                st_next   = ST_DIV;
                if (cmd_reg.func == FUNC_INSERT)
                begin
                    if (!((lo_reg < cnt_reg) && (rkey == cmd_reg.key)))
                    begin
                        if (cnt_reg >= NW'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            idx_next   = cnt_reg;
                            phase_next = 1'b0;
                            hold_next  = {cmd_reg.key, cmd_reg.has_grade,
                                          cmd_reg.has_grade ? cmd_reg.grade_tenths
                                                            : GRADE_W'(0)};
                            if (cmd_reg.has_grade)
                            begin
                                gcnt_next = gcnt_reg + 1'b1;
                                gsum_next = gsum_reg + SUM_W'(cmd_reg.grade_tenths);
                            end
                            cnt_next = cnt_reg + 1'b1;
                            st_next  = ST_SHIFT;
                        end
                    end
                end
                else if ((lo_reg < cnt_reg) && (rkey == cmd_reg.key))
                begin
                    if (rflag)
                    begin
                        if (gcnt_reg != '0)
                        begin
                            gcnt_next = gcnt_reg - 1'b1;
                        end
                        gsum_next = (gsum_reg >= sub_g) ? gsum_reg - sub_g : '0;
                    end
                    idx_next   = lo_reg;
                    phase_next = 1'b0;
                    cnt_next   = cnt_reg - 1'b1;
                    st_next    = ST_SHIFT;
                end
                rem_next  = '0;
                dcnt_next = '0;
                quo_next  = gsum_next;
            end
            ST_SHIFT:
            begin
                if (cmd_reg.func == FUNC_INSERT)
                begin
                    if (idx_reg == lo_reg)
                    begin
                        wen     = 1'b1;
                        st_next = ST_DIV;
                    end
                    else if (!phase_reg)
                    begin
                        ren        = 1'b1;
                        raddr      = AW'(idx_reg - 1'b1);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        wen        = 1'b1;
                        wdata      = rdata_reg;
                        idx_next   = idx_reg - 1'b1;
                        phase_next = 1'b0;
                    end
                end
                else
                begin
                    if (idx_reg + 1'b1 > cnt_reg)
                    begin
                        st_next = ST_DIV;
                    end
                    else if (!phase_reg)
                    begin
                        ren        = 1'b1;
                        raddr      = AW'(idx_reg + 1'b1);
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        wen        = 1'b1;
                        wdata      = rdata_reg;
                        idx_next   = idx_reg + 1'b1;
                        phase_next = 1'b0;
                    end
                end
                rem_next  = '0;
                dcnt_next = '0;
                quo_next  = gsum_next;
            end
            ST_DIV:
            begin
                // restoring divider: shift dividend bits MSB first from quo into rem
                if (gcnt_reg == '0)
                begin
                    st_next = ST_OUT;
                end
                else
                begin
                    if (trial >= SUM_W'(gcnt_reg))
                    begin
                        rem_next = trial - SUM_W'(gcnt_reg);
                        quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial;
                        quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg + 1'b1;
                    if (dcnt_reg == 4'(SUM_W-1))
                    begin
                        st_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                if (!rv_reg || res_ready)
                begin
                    load_res = 1'b1;
                    res_next.key_was_present = pres_reg;
                    res_next.table_full      = full_reg;
                    res_next.set_size        = CNT_W'(cnt_reg);
                    res_next.graded_count    = gcnt_reg;
                    res_next.mean_grade_tenths = (gcnt_reg == '0) ? MEAN_NONE
                                                 : MEAN_W'(quo_reg);
                    st_next = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            cnt_reg  <= '0;
            gcnt_reg <= '0;
            gsum_reg <= '0;
            rv_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            gcnt_reg <= gcnt_next;
            gsum_reg <= gsum_next;
            if (load_res)
            begin
                rv_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                rv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid)
        begin
            cmd_reg <= q_cmd;
        end
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        idx_reg   <= idx_next;
        pres_reg  <= pres_next;
        full_reg  <= full_next;
        phase_reg <= phase_next;
        hold_reg  <= hold_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dcnt_reg  <= dcnt_next;
        res_reg   <= res_next;
    end
endmodule

@@ hdl/sorted_key_set_with_running_mean.sv @@
// Top level: sorted key set with running mean grade.
// Channel | Dir | Fields
// s_axis  | in  | tdata: func, key, has_grade, grade_tenths
// m_axis  | out | tdata: key_was_present, table_full, set_size, graded_count, mean
// One operation at a time in the back part: a binary search, a shift of the
// entries behind the slot when the set changes, a serial divider for the mean
// (skipped when nothing is graded), then the output state.
// A waiting result holds the back part in its output state.
// Reset clears counts and control; record memory needs no clearing.
// Two-entry queue decouples input from the back part; output is registered.
module sorted_key_set_with_running_mean (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // func, key[27], has_grade, grade_tenths[7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // key_was_present, table_full, set_size[7],
                                       // graded_count[7], mean_grade_tenths[8]
);
    import sksm_pkg::*;

    sksm_cmd_t in_cmd, q_cmd;
    sksm_res_t res;
    logic      q_valid, q_ready;

    assign in_cmd.func         = s_axis_tdata[0];
    assign in_cmd.key          = s_axis_tdata[27:1];
    assign in_cmd.has_grade    = s_axis_tdata[28];
    assign in_cmd.grade_tenths = s_axis_tdata[35:29];

    sksm_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
    );

    sksm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
    );

    assign m_axis_tdata = {res.mean_grade_tenths, res.graded_count, res.set_size,
                           res.table_full, res.key_was_present};
endmodule

@@ hdl/sksm_checker.sv @@
// Port-level checker for the sorted key set, bound to the top level.
`include "assert_macros.svh"
module sksm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    logic       stall;
    logic       present_f;
    logic       full_f;
    logic [6:0] size_f;
    logic [6:0] graded_f;
    logic [7:0] mean_f;

    assign stall     = m_axis_tvalid && !m_axis_tready;
    assign present_f = m_axis_tdata[0];
    assign full_f    = m_axis_tdata[1];
    assign size_f    = m_axis_tdata[8:2];
    assign graded_f  = m_axis_tdata[15:9];
    assign mean_f    = m_axis_tdata[23:16];

    `ASSERT_CLK(a_out_hold, clk, rst_n, stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ASSERT_CLK(a_full_not_present, clk, rst_n, m_axis_tvalid |-> !(present_f && full_f), "full and present")
    `ASSERT_CLK(a_graded_le_size, clk, rst_n, m_axis_tvalid |-> graded_f <= size_f, "graded above size")
    `ASSERT_CLK(a_mean_none, clk, rst_n, m_axis_tvalid && graded_f == 7'd0 |-> mean_f == 8'hFF, "mean not -1")
    `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !m_axis_tvalid, "result valid in reset")
endmodule

bind sorted_key_set_with_running_mean sksm_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

@@ tb/sv/sksm_scoreboard.sv @@
// Checker: predicts sorted key set results and compares the output stream.
`timescale 1ns / 100ps
module sksm_scoreboard (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    output int          errors,
    output int          pending
);
    import sksm_pkg::*;

    logic [KEY_W-1:0]   keys [CAPACITY];
    logic               graded [CAPACITY];
    logic [GRADE_W-1:0] grades [CAPACITY];
    int unsigned        n_rec;
    int unsigned        n_graded;
    int unsigned        grade_total;
    sksm_res_t          expected_q[$];

    function automatic sksm_res_t apply_op(logic func, logic [KEY_W-1:0] k, logic has,
                                           logic [GRADE_W-1:0] g);
        sksm_res_t   r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        bit          hit;
        lo = 0;
        hi = n_rec;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (keys[mid] < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < n_rec) && (keys[lo] == k);
        r = '0;
        r.key_was_present = hit;
        if (func == FUNC_INSERT)
        begin
            if (!hit)
            begin
                if (n_rec >= CAPACITY)
                    r.table_full = 1'b1;
                else
                begin
                    for (int i = n_rec; i > lo; i--)
                    begin
                        keys[i]   = keys[i-1];
                        graded[i] = graded[i-1];
                        grades[i] = grades[i-1];
                    end
                    keys[lo]   = k;
                    graded[lo] = has;
                    grades[lo] = has ? g : '0;
                    n_rec++;
                    if (has)
                    begin
                        n_graded++;
                        grade_total += g;
                    end
                end
            end
        end
        else if (hit)
        begin
            if (graded[lo])
            begin
                n_graded--;
                grade_total -= grades[lo];
            end
            for (int i = lo; i + 1 < n_rec; i++)
            begin
                keys[i]   = keys[i+1];
                graded[i] = graded[i+1];
                grades[i] = grades[i+1];
            end
            n_rec--;
        end
        r.set_size     = n_rec[CNT_W-1:0];
        r.graded_count = n_graded[CNT_W-1:0];
        if (n_graded == 0)
            r.mean_grade_tenths = MEAN_NONE;
        else
            r.mean_grade_tenths = MEAN_W'(grade_total / n_graded);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sksm_res_t exp_r;
        sksm_res_t got;
        if (!rst_n)
        begin
            n_rec = 0;
            n_graded = 0;
            grade_total = 0;
            errors = 0;
            expected_q.delete();
            pending = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(apply_op(s_axis_tdata[0], s_axis_tdata[27:1],
                                              s_axis_tdata[28], s_axis_tdata[35:29]));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.key_was_present   = m_axis_tdata[0];
                got.table_full        = m_axis_tdata[1];
                got.set_size          = m_axis_tdata[8:2];
                got.graded_count      = m_axis_tdata[15:9];
                got.mean_grade_tenths = m_axis_tdata[23:16];
                if (expected_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transaction %h", m_axis_tdata);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (got !== exp_r)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("mismatch: exp present=%0d full=%0d size=%0d %s%0d mean=%0d",
                                     exp_r.key_was_present, exp_r.table_full,
                                     exp_r.set_size, "graded=", exp_r.graded_count,
                                     exp_r.mean_grade_tenths);
                            $display("          got present=%0d full=%0d size=%0d %s%0d mean=%0d",
                                     got.key_was_present, got.table_full,
                                     got.set_size, "graded=", got.graded_count,
                                     got.mean_grade_tenths);
                        end
                    end
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

@@ tb/sv/tb_sorted_key_set_with_running_mean.sv @@
// Testbench top: stimulus, output backpressure and verdict for the sorted key set.
`timescale 1ns / 100ps
module tb_sorted_key_set_with_running_mean;
    import sksm_pkg::*;

    localparam int  KEY_MAX   = (1 << KEY_W) - 1;
    localparam int  LIMIT     = 600000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    int          errors;
    int          pending;
    int          cycles;
    bit          rx_busy_mode;
    logic [KEY_W-1:0] key_pool [48];

    sorted_key_set_with_running_mean DUT (.*);

    sksm_scoreboard CHK (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_op(logic func, logic [KEY_W-1:0] k, logic has, logic [GRADE_W-1:0] g,
                           int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {4'b0, g, has, k, func};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic int draw_gap();
        return rx_busy_mode ? $urandom_range(0, 12) : 0;
    endfunction

    // Receiver: per-transaction stall, with stretches of none.
    initial
    begin
        int w;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_busy_mode <= ~rx_busy_mode;
            w = draw_gap();
            if (w > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    initial
    begin
        int       n;
        int       bias;
        int       gap;
        logic     f;
        logic [KEY_W-1:0] k;
        cycles        = 0;
        rx_busy_mode  = 1'b1;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        for (int i = 0; i < 48; i++)
            key_pool[i] = KEY_W'($urandom_range(0, KEY_MAX));
        key_pool[0] = '0;
        key_pool[1] = KEY_W'(KEY_MAX);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_op(FUNC_DELETE, 27'd5, 1'b0, 7'd0, 0);
        send_op(FUNC_INSERT, '0, 1'b0, 7'd127, 0);
        send_op(FUNC_INSERT, KEY_W'(KEY_MAX), 1'b1, 7'd127, 0);
        send_op(FUNC_INSERT, 27'd1000, 1'b1, 7'd0, 1);
        send_op(FUNC_INSERT, 27'd500, 1'b1, 7'd100, 0);
        send_op(FUNC_INSERT, 27'd500, 1'b1, 7'd3, 2);
        send_op(FUNC_INSERT, 27'd99999999, 1'b1, 7'd55, 0);
        send_op(FUNC_DELETE, 27'd501, 1'b0, 7'd0, 0);
        send_op(FUNC_DELETE, KEY_W'(KEY_MAX), 1'b1, 7'd127, 0);
        send_op(FUNC_DELETE, '0, 1'b0, 7'd0, 3);
        send_op(FUNC_DELETE, 27'd1000, 1'b0, 7'd0, 0);
        send_op(FUNC_DELETE, 27'd500, 1'b0, 7'd0, 0);
        send_op(FUNC_DELETE, 27'd99999999, 1'b0, 7'd0, 0);
        send_op(FUNC_INSERT, 27'h2AAAAAA, 1'b1, 7'h55, 0);
        send_op(FUNC_INSERT, 27'h5555555, 1'b1, 7'h2A, 0);
        send_op(FUNC_DELETE, 27'h2AAAAAA, 1'b0, 7'd0, 0);

        // random: phases of insert bias fill the table to full, delete bias drains it
        n = 0;
        while (n < 450)
        begin
            bias = (n / 90) % 2 == 0 ? 85 : 25;
            for (int j = 0; j < 90 && n < 450; j++)
            begin
                f = ($urandom_range(0, 99) < bias) ? FUNC_INSERT : FUNC_DELETE;
                if ($urandom_range(0, 9) < 7)
                    k = KEY_W'(key_pool[$urandom_range(0, 47)]
                               + $urandom_range(0, 1) * 64'(j % 40));
                else
                    k = KEY_W'($urandom_range(0, KEY_MAX));
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                send_op(f, k, 1'($urandom_range(0, 1)), GRADE_W'($urandom_range(0, 127)),
                        gap);
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
